@@ rtl/olt_pkg.sv @@
package olt_pkg;

  // Number of CORDIC micro-rotations.
  localparam int CORDIC_STAGES = 20;
  // Register depth from the angle input to the registered sine and cosine.
  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  // Heading quantization used when the top level is not overridden.
  localparam int DEF_ANGLE_BITS = 16;

  // Width of the CORDIC datapath: Q4.30 x and y, 2^-32 turn z with headroom.
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh26DD3B6A;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      default: v = 32'h00000000;
    endcase
    return CW'(v);
  endfunction

endpackage

@@ rtl/olt_cordic.sv @@
module olt_cordic import olt_pkg::*; #(
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [15:0] cos_q15,
  output logic signed [15:0] sin_q15
);

  // Heading bits below the configured resolution are dropped.
  localparam int DROP = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
  localparam logic [15:0] KEEP = 16'hFFFF << DROP;

  logic signed [CW-1:0] x_r [0:CORDIC_STAGES];
  logic signed [CW-1:0] y_r [0:CORDIC_STAGES];
  logic signed [CW-1:0] z_r [0:CORDIC_STAGES];
  logic                 f_r [0:CORDIC_STAGES];
  logic signed [15:0]   cos_r, sin_r;

  logic [31:0] turn;
  logic [31:0] turn_red;
  logic        flip;

  // Fold the second and third quadrant into [-pi/2, pi/2).
  always_comb begin
    turn = {angle & KEEP, 16'h0000};
    flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
    turn_red = flip ? (turn ^ 32'h80000000) : turn;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= CW'($signed(turn_red));
      f_r[0] <= flip;
    end
  end

  // One micro-rotation per register stage.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_turn(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_turn(5'(i));
        end
        f_r[i+1] <= f_r[i];
      end
    end
  end

  // Round to Q1.15, saturate symmetrically, then undo the quadrant fold.
  function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v,
                                                input logic neg);
    logic signed [CW-1:0] r;
    logic signed [15:0]   q;
    r = (v + CW'(16384)) >>> 15;
    if (r > CW'(32767)) begin
      q = 16'sd32767;
    end else if (r < -CW'(32767)) begin
      q = -16'sd32767;
    end else begin
      q = r[15:0];
    end
    return neg ? -q : q;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= to_q15(x_r[CORDIC_STAGES], f_r[CORDIC_STAGES]);
      sin_r <= to_q15(y_r[CORDIC_STAGES], f_r[CORDIC_STAGES]);
    end
  end

  assign cos_q15 = cos_r;
  assign sin_q15 = sin_r;

endmodule

@@ rtl/oriented_box_overlap_test_unit.sv @@
// Channel | Direction | Ports                                  | Item
// in      | slave     | in_tvalid, in_tready, in_tdata[191:0]   | two rectangles
// out     | master    | out_tvalid, out_tready, out_tdata[7:0]  | overlap flag
//
// Each item passes the CORDIC pipeline, four projection stages and a compare
// into the output register. One item enters per cycle while not stalled.
// Reset clears only the valid bits; the datapath carries no reset.
// A stall on the output freezes the whole pipeline in place, so in_tready
// follows out_tready whenever a result is held.
module oriented_box_overlap_test_unit import olt_pkg::*; #(
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, a_heading, a_half_length, a_half_width,
  // b_x, b_y, b_heading, b_half_length, b_half_width
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // overlap, then zero fill
  output logic [7:0]   out_tdata
);

  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [15:0]        ahl;
    logic [15:0]        ahw;
    logic [15:0]        bhl;
    logic [15:0]        bhw;
  } side_t;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // Field unpacking.
  logic signed [23:0] a_x, a_y, b_x, b_y;
  logic [15:0] a_heading, b_heading;
  assign a_x       = in_tdata[23:0];
  assign a_y       = in_tdata[47:24];
  assign a_heading = in_tdata[63:48];
  assign b_x       = in_tdata[119:96];
  assign b_y       = in_tdata[143:120];
  assign b_heading = in_tdata[159:144];

  // Sine and cosine of both headings.
  logic signed [15:0] ca, sa, cb, sb;

  olt_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_a (
    .clk(clk), .en(en), .angle(a_heading), .cos_q15(ca), .sin_q15(sa)
  );

  olt_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_b (
    .clk(clk), .en(en), .angle(b_heading), .cos_q15(cb), .sin_q15(sb)
  );

  // Offset and extents travel alongside the CORDIC pipeline.
  side_t sd_r [0:CORDIC_LAT-1];
  logic  v_r  [0:CORDIC_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0].dx  <= 25'(b_x) - 25'(a_x);
      sd_r[0].dy  <= 25'(b_y) - 25'(a_y);
      sd_r[0].ahl <= in_tdata[79:64];
      sd_r[0].ahw <= in_tdata[95:80];
      sd_r[0].bhl <= in_tdata[175:160];
      sd_r[0].bhw <= in_tdata[191:176];
      for (int i = 1; i < CORDIC_LAT; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORDIC_LAT; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  side_t sd;
  assign sd = sd_r[CORDIC_LAT-1];

  // Stage 1: products among the trig values and of the offset with each trig value.
  logic signed [31:0] caa_r, saa_r, cbb_r, sbb_r, cab_r, sab_r, casb_r, sacb_r;
  logic signed [40:0] dxca_r, dysa_r, dxsa_r, dyca_r, dxcb_r, dysb_r, dxsb_r, dycb_r;
  logic [15:0] t1_ahl_r, t1_ahw_r, t1_bhl_r, t1_bhw_r;
  logic        t1_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      caa_r  <= 32'(ca) * 32'(ca);
      saa_r  <= 32'(sa) * 32'(sa);
      cbb_r  <= 32'(cb) * 32'(cb);
      sbb_r  <= 32'(sb) * 32'(sb);
      cab_r  <= 32'(ca) * 32'(cb);
      sab_r  <= 32'(sa) * 32'(sb);
      casb_r <= 32'(ca) * 32'(sb);
      sacb_r <= 32'(sa) * 32'(cb);
      dxca_r <= 41'(sd.dx) * 41'(ca);
      dysa_r <= 41'(sd.dy) * 41'(sa);
      dxsa_r <= 41'(sd.dx) * 41'(sa);
      dyca_r <= 41'(sd.dy) * 41'(ca);
      dxcb_r <= 41'(sd.dx) * 41'(cb);
      dysb_r <= 41'(sd.dy) * 41'(sb);
      dxsb_r <= 41'(sd.dx) * 41'(sb);
      dycb_r <= 41'(sd.dy) * 41'(cb);
      t1_ahl_r <= sd.ahl;
      t1_ahw_r <= sd.ahw;
      t1_bhl_r <= sd.bhl;
      t1_bhw_r <= sd.bhw;
    end
  end

  function automatic logic [41:0] abs42(input logic signed [41:0] v);
    return v[41] ? 42'(-v) : 42'(v);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Stage 2: squared norms, cross terms and separations on the four axes.
  logic [31:0] na_r, nb_r, p_r, q_r;
  logic [41:0] sep_r [0:3];
  logic [15:0] t2_ahl_r, t2_ahw_r, t2_bhl_r, t2_bhw_r;
  logic        t2_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      na_r <= 32'(caa_r + saa_r);
      nb_r <= 32'(cbb_r + sbb_r);
      p_r  <= abs32(cab_r + sab_r);
      q_r  <= abs32(casb_r - sacb_r);
      sep_r[0] <= abs42(42'(dxca_r) + 42'(dysa_r));
      sep_r[1] <= abs42(42'(dyca_r) - 42'(dxsa_r));
      sep_r[2] <= abs42(42'(dxcb_r) + 42'(dysb_r));
      sep_r[3] <= abs42(42'(dycb_r) - 42'(dxsb_r));
      t2_ahl_r <= t1_ahl_r;
      t2_ahw_r <= t1_ahw_r;
      t2_bhl_r <= t1_bhl_r;
      t2_bhw_r <= t1_bhw_r;
    end
  end

  // Stage 3: extent products.
  logic [47:0] ahl_na_r, ahw_na_r, ahl_p_r, ahw_q_r, ahl_q_r, ahw_p_r;
  logic [47:0] bhl_p_r, bhw_q_r, bhl_q_r, bhw_p_r, bhl_nb_r, bhw_nb_r;
  logic [41:0] t3_sep_r [0:3];
  logic        t3_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ahl_na_r <= 48'(t2_ahl_r) * 48'(na_r);
      ahw_na_r <= 48'(t2_ahw_r) * 48'(na_r);
      ahl_p_r  <= 48'(t2_ahl_r) * 48'(p_r);
      ahw_q_r  <= 48'(t2_ahw_r) * 48'(q_r);
      ahl_q_r  <= 48'(t2_ahl_r) * 48'(q_r);
      ahw_p_r  <= 48'(t2_ahw_r) * 48'(p_r);
      bhl_p_r  <= 48'(t2_bhl_r) * 48'(p_r);
      bhw_q_r  <= 48'(t2_bhw_r) * 48'(q_r);
      bhl_q_r  <= 48'(t2_bhl_r) * 48'(q_r);
      bhw_p_r  <= 48'(t2_bhw_r) * 48'(p_r);
      bhl_nb_r <= 48'(t2_bhl_r) * 48'(nb_r);
      bhw_nb_r <= 48'(t2_bhw_r) * 48'(nb_r);
      for (int k = 0; k < 4; k++) begin
        t3_sep_r[k] <= sep_r[k];
      end
    end
  end

  // Stage 4: summed projected extents per axis.
  logic [49:0] tot_r [0:3];
  logic [41:0] t4_sep_r [0:3];
  logic        t4_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tot_r[0] <= 50'(ahl_na_r) + 50'(bhl_p_r) + 50'(bhw_q_r);
      tot_r[1] <= 50'(ahw_na_r) + 50'(bhl_q_r) + 50'(bhw_p_r);
      tot_r[2] <= 50'(ahl_p_r) + 50'(ahw_q_r) + 50'(bhl_nb_r);
      tot_r[3] <= 50'(ahl_q_r) + 50'(ahw_p_r) + 50'(bhw_nb_r);
      for (int k = 0; k < 4; k++) begin
        t4_sep_r[k] <= t3_sep_r[k];
      end
    end
  end

  // Output: overlap unless some axis separates strictly.
  logic overlap_nxt, overlap_r, out_tvalid_r;

  always_comb begin
    overlap_nxt = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if ({t4_sep_r[k], 15'b0} > 57'(tot_r[k])) begin
        overlap_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap_r <= overlap_nxt;
    end
  end

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r       <= 1'b0;
      t2_v_r       <= 1'b0;
      t3_v_r       <= 1'b0;
      t4_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      t1_v_r       <= v_r[CORDIC_LAT-1];
      t2_v_r       <= t1_v_r;
      t3_v_r       <= t2_v_r;
      t4_v_r       <= t3_v_r;
      out_tvalid_r <= t4_v_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, overlap_r};

  // A held result freezes the stages behind it.
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(t4_v_r) && $stable(t3_v_r)))
    else $error("pipeline advanced during output stall");

  // Coincident centers can never be separated.
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (en && t4_v_r && t4_sep_r[0] == '0 && t4_sep_r[1] == '0 &&
     t4_sep_r[2] == '0 && t4_sep_r[3] == '0) |=> out_tdata[0])
    else $error("zero offset reported as separated");

  // An accepted item reaches the first arithmetic stage after the CORDIC.
  a_valid_path: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[CORDIC_LAT-1]) |=> t1_v_r)
    else $error("item lost between CORDIC and projection stages");

endmodule
